FILE: rtl/skt_pkg.sv
// Shared constants and codes of the sorted key table.
package skt_pkg;
  localparam int CAPACITY     = 64;
  localparam int KEY_BITS     = 21;
  localparam int PAYLOAD_BITS = 16;
  localparam int CMD_W        = 3;
  localparam int STAT_W       = 3;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd4;
endpackage

FILE: rtl/skt_if.sv
// Command and result channel interfaces of the sorted key table.
interface skt_cmd_if #(
  parameter int CAPACITY     = skt_pkg::CAPACITY,
  parameter int KEY_BITS     = skt_pkg::KEY_BITS,
  parameter int PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS
);
  localparam int IDX_W = $clog2(CAPACITY);
  logic                       valid;
  logic                       ready;
  logic [skt_pkg::CMD_W-1:0]  cmd;
  logic [KEY_BITS-1:0]        key;
  logic [PAYLOAD_BITS-1:0]    payload;
  logic [IDX_W-1:0]           position;
  logic                       use_alphabet;
  modport source (output valid, cmd, key, payload, position, use_alphabet, input ready);
  modport sink   (input valid, cmd, key, payload, position, use_alphabet, output ready);
endinterface

interface skt_res_if #(
  parameter int CAPACITY     = skt_pkg::CAPACITY,
  parameter int KEY_BITS     = skt_pkg::KEY_BITS,
  parameter int PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS
);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  logic                       valid;
  logic                       ready;
  logic [skt_pkg::STAT_W-1:0] status;
  logic [IDX_W-1:0]           found_index;
  logic [KEY_BITS-1:0]        found_key;
  logic [PAYLOAD_BITS-1:0]    found_payload;
  logic [CNT_W-1:0]           entry_total;
  logic [CNT_W-1:0]           alphabet_total;
  modport source (output valid, status, found_index, found_key, found_payload,
                  entry_total, alphabet_total, input ready);
  modport sink   (input valid, status, found_index, found_key, found_payload,
                  entry_total, alphabet_total, output ready);
endinterface

FILE: rtl/sorted_key_table.sv
// Sorted key table top level: memories, binary search and shift sequencer.
// The block keeps key/payload entries in ascending key order in a single-port
// synchronous memory, plus a key-only alphabet table in a second memory. It
// works on one command word at a time. Every memory access is issued first,
// and its data comes back in a register. A search is a binary search with a
// final hit check, an insert then moves each entry at or above its slot up by
// one, a delete moves each entry above it down by one, and an alphabet
// insert repeats search and shift in the second memory. Read at position does
// one memory read; clear only resets the counts. A finished result word waits
// in the output register while the next command word is taken.
module sorted_key_table #(
  parameter int CAPACITY     = skt_pkg::CAPACITY,
  parameter int KEY_BITS     = skt_pkg::KEY_BITS,
  parameter int PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  skt_cmd_if.sink   in_ch,
  skt_res_if.source out_ch
);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_HITC = 4'd3;
  localparam logic [3:0] S_DEC  = 4'd4;
  localparam logic [3:0] S_SHR  = 4'd5;
  localparam logic [3:0] S_SHW  = 4'd6;
  localparam logic [3:0] S_DLR  = 4'd7;
  localparam logic [3:0] S_DLW  = 4'd8;
  localparam logic [3:0] S_RDW  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [KEY_BITS-1:0]     tbl_key_mem [CAPACITY];
  logic [PAYLOAD_BITS-1:0] tbl_pay_mem [CAPACITY];
  logic [KEY_BITS-1:0]     alp_key_mem [CAPACITY];

  logic [KEY_BITS-1:0]     tbl_key_rd_r, alp_key_rd_r;
  logic [PAYLOAD_BITS-1:0] tbl_pay_rd_r;

  logic [3:0] state_r, state_nxt;
  logic [skt_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic ua_r, ua_nxt, alpha_r, alpha_nxt, hit_r, hit_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, acnt_r, acnt_nxt;
  logic [skt_pkg::STAT_W-1:0] st_r, st_nxt;
  logic [IDX_W-1:0] fi_r, fi_nxt;
  logic [KEY_BITS-1:0] fk_r, fk_nxt;
  logic [PAYLOAD_BITS-1:0] fp_r, fp_nxt;

  logic ov_r, ov_nxt;
  logic [skt_pkg::STAT_W-1:0] o_st_r, o_st_nxt;
  logic [IDX_W-1:0] o_fi_r, o_fi_nxt;
  logic [KEY_BITS-1:0] o_fk_r, o_fk_nxt;
  logic [PAYLOAD_BITS-1:0] o_fp_r, o_fp_nxt;
  logic [CNT_W-1:0] o_et_r, o_et_nxt, o_at_r, o_at_nxt;

  logic rd_en, tbl_we, alp_we;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [KEY_BITS-1:0] wr_key;
  logic [PAYLOAD_BITS-1:0] wr_pay;
  logic [KEY_BITS-1:0] rd_key;
  logic [CNT_W-1:0] n_cur;
  logic [CNT_W:0] mid_sum;
  logic in_fire;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign rd_key = alpha_r ? alp_key_rd_r : tbl_key_rd_r;
  assign n_cur = alpha_r ? acnt_r : cnt_r;
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};

  assign out_ch.valid = ov_r;
  assign out_ch.status = o_st_r;
  assign out_ch.found_index = o_fi_r;
  assign out_ch.found_key = o_fk_r;
  assign out_ch.found_payload = o_fp_r;
  assign out_ch.entry_total = o_et_r;
  assign out_ch.alphabet_total = o_at_r;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    key_nxt = key_r;
    pay_nxt = pay_r;
    ua_nxt = ua_r;
    alpha_nxt = alpha_r;
    hit_nxt = hit_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    mid_nxt = mid_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    acnt_nxt = acnt_r;
    st_nxt = st_r;
    fi_nxt = fi_r;
    fk_nxt = fk_r;
    fp_nxt = fp_r;
    ov_nxt = ov_r && !out_ch.ready;
    o_st_nxt = o_st_r;
    o_fi_nxt = o_fi_r;
    o_fk_nxt = o_fk_r;
    o_fp_nxt = o_fp_r;
    o_et_nxt = o_et_r;
    o_at_nxt = o_at_r;
    rd_en = 1'b0;
    rd_addr = '0;
    tbl_we = 1'b0;
    alp_we = 1'b0;
    wr_addr = '0;
    wr_key = '0;
    wr_pay = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt = in_ch.cmd;
          key_nxt = in_ch.key;
          pay_nxt = in_ch.payload;
          ua_nxt = in_ch.use_alphabet;
          alpha_nxt = 1'b0;
          lo_nxt = '0;
          hi_nxt = cnt_r;
          st_nxt = skt_pkg::ST_OK;
          fi_nxt = '0;
          fk_nxt = '0;
          fp_nxt = '0;
          case (in_ch.cmd)
            skt_pkg::CMD_INSERT, skt_pkg::CMD_LOOKUP, skt_pkg::CMD_DELETE: begin
              state_nxt = S_SRCH;
            end
            skt_pkg::CMD_READ: begin
              if (CNT_W'(in_ch.position) < cnt_r) begin
                rd_en = 1'b1;
                rd_addr = in_ch.position;
                fi_nxt = in_ch.position;
                state_nxt = S_RDW;
              end else begin
                st_nxt = skt_pkg::ST_BAD_POS;
                state_nxt = S_DONE;
              end
            end
            skt_pkg::CMD_CLEAR: begin
              cnt_nxt = '0;
              acnt_nxt = '0;
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt = mid_sum[CNT_W:1];
          rd_en = 1'b1;
          rd_addr = mid_sum[IDX_W:1];
          state_nxt = S_SCMP;
        end else if (lo_r < n_cur) begin
          rd_en = 1'b1;
          rd_addr = lo_r[IDX_W-1:0];
          state_nxt = S_HITC;
        end else begin
          hit_nxt = 1'b0;
          state_nxt = S_DEC;
        end
      end
      S_SCMP: begin
        if (rd_key < key_r) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_SRCH;
      end
      S_HITC: begin
        hit_nxt = (rd_key == key_r);
        state_nxt = S_DEC;
      end
      S_DEC: begin
        state_nxt = S_DONE;
        if (alpha_r) begin
          if (!hit_r && acnt_r != CAP_C) begin
            idx_nxt = acnt_r;
            state_nxt = S_SHR;
          end
        end else begin
          case (cmd_r)
            skt_pkg::CMD_INSERT: begin
              if (hit_r) begin
                st_nxt = skt_pkg::ST_DUPLICATE;
                fi_nxt = lo_r[IDX_W-1:0];
                fk_nxt = tbl_key_rd_r;
                fp_nxt = tbl_pay_rd_r;
              end else if (cnt_r == CAP_C) begin
                st_nxt = skt_pkg::ST_FULL;
              end else begin
                fi_nxt = lo_r[IDX_W-1:0];
                fk_nxt = key_r;
                fp_nxt = pay_r;
                idx_nxt = cnt_r;
                state_nxt = S_SHR;
              end
            end
            skt_pkg::CMD_LOOKUP, skt_pkg::CMD_DELETE: begin
              if (hit_r) begin
                fi_nxt = lo_r[IDX_W-1:0];
                fk_nxt = tbl_key_rd_r;
                fp_nxt = tbl_pay_rd_r;
                if (cmd_r == skt_pkg::CMD_DELETE) begin
                  idx_nxt = lo_r;
                  state_nxt = S_DLR;
                end
              end else begin
                st_nxt = skt_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SHR: begin
        if (idx_r > lo_r) begin
          rd_en = 1'b1;
          rd_addr = IDX_W'(idx_r - 1'b1);
          state_nxt = S_SHW;
        end else begin
          wr_addr = lo_r[IDX_W-1:0];
          wr_key = key_r;
          wr_pay = pay_r;
          if (alpha_r) begin
            alp_we = 1'b1;
            acnt_nxt = acnt_r + 1'b1;
            state_nxt = S_DONE;
          end else begin
            tbl_we = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            if (ua_r) begin
              alpha_nxt = 1'b1;
              lo_nxt = '0;
              hi_nxt = acnt_r;
              state_nxt = S_SRCH;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_SHW: begin
        wr_addr = idx_r[IDX_W-1:0];
        wr_key = rd_key;
        wr_pay = tbl_pay_rd_r;
        tbl_we = !alpha_r;
        alp_we = alpha_r;
        idx_nxt = idx_r - 1'b1;
        state_nxt = S_SHR;
      end
      S_DLR: begin
        if (CNT_W'(idx_r + 1'b1) < cnt_r) begin
          rd_en = 1'b1;
          rd_addr = IDX_W'(idx_r + 1'b1);
          state_nxt = S_DLW;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DLW: begin
        tbl_we = 1'b1;
        wr_addr = idx_r[IDX_W-1:0];
        wr_key = tbl_key_rd_r;
        wr_pay = tbl_pay_rd_r;
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_DLR;
      end
      S_RDW: begin
        fk_nxt = tbl_key_rd_r;
        fp_nxt = tbl_pay_rd_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          o_st_nxt = st_r;
          o_fi_nxt = fi_r;
          o_fk_nxt = fk_r;
          o_fp_nxt = fp_r;
          o_et_nxt = cnt_r;
          o_at_nxt = acnt_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      tbl_key_rd_r <= tbl_key_mem[rd_addr];
      tbl_pay_rd_r <= tbl_pay_mem[rd_addr];
      alp_key_rd_r <= alp_key_mem[rd_addr];
    end
    if (tbl_we) begin
      tbl_key_mem[wr_addr] <= wr_key;
      tbl_pay_mem[wr_addr] <= wr_pay;
    end
    if (alp_we) begin
      alp_key_mem[wr_addr] <= wr_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      acnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      acnt_r <= acnt_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    pay_r <= pay_nxt;
    ua_r <= ua_nxt;
    alpha_r <= alpha_nxt;
    hit_r <= hit_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    mid_r <= mid_nxt;
    idx_r <= idx_nxt;
    st_r <= st_nxt;
    fi_r <= fi_nxt;
    fk_r <= fk_nxt;
    fp_r <= fp_nxt;
    o_st_r <= o_st_nxt;
    o_fi_r <= o_fi_nxt;
    o_fk_r <= o_fk_nxt;
    o_fp_r <= o_fp_nxt;
    o_et_r <= o_et_nxt;
    o_at_r <= o_at_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CAP_C)
    else $error("Entry count exceeds capacity.");
  a_acnt_bound: assert property (@(posedge clk) disable iff (!rst_n) acnt_r <= CAP_C)
    else $error("Alphabet count exceeds capacity.");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("Command word accepted without leaving idle.");
  a_shift_above_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHW |-> idx_r > lo_r)
    else $error("Shift write at or below the insert slot.");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r) == S_DONE)
    else $error("Result word raised outside the done state.");
endmodule
